FILE: rtl/core/lpkt_pkg.sv
// ----------------------------------------------------------------------------
// lpkt_pkg
// Shared types, codes and sizes of the linear probe key table.
// ----------------------------------------------------------------------------
package lpkt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int DATA_WIDTH  = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = IDX_W + 1;

  // fixed field widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 16;
  localparam int FIELD_W  = 32;
  localparam int STAT_W   = 2;
  localparam int SLOT_W   = 8;
  localparam int CFG_W    = 9;
  localparam int DIV_CNT_W = $clog2(KEY_W + 1);

  // request queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // opcodes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK   = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  // classified request handed from front to back
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [FIELD_W-1:0] data;
    logic [IDX_W-1:0]   home;
  } req_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_HOLD
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_CMP,
    B_DONE
  } back_state_t;

endpackage

FILE: rtl/core/lpkt_ram.sv
// ----------------------------------------------------------------------------
// lpkt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpkt_ram #(
  parameter  int WIDTH  = 32,
  parameter  int DEPTH  = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/lpkt_front.sv
// ----------------------------------------------------------------------------
// lpkt_front
// Accepts requests and computes the home slot (key modulo table size)
// with a one bit per cycle restoring remainder unit.
// ----------------------------------------------------------------------------
module lpkt_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [lpkt_pkg::OP_W-1:0]        in_opcode,
  input  logic [lpkt_pkg::KEY_W-1:0]       in_key,
  input  logic [lpkt_pkg::FIELD_W-1:0]     in_entry_data,
  input  logic [lpkt_pkg::SIZE_W-1:0]      size_n,
  output logic                             req_valid,
  input  logic                             req_ready,
  output lpkt_pkg::req_t                   req
);
  import lpkt_pkg::*;

  front_state_t         state_r, state_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [FIELD_W-1:0]   data_r, data_nxt;
  logic [KEY_W-1:0]     shift_r, shift_nxt;
  logic [SIZE_W-1:0]    rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]    rem_sh;

  // one remainder step: shift in next key bit, subtract once if possible
  assign rem_sh = {rem_r[SIZE_W-2:0], shift_r[KEY_W-1]};

  // next state and outputs
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    data_nxt  = data_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    in_full   = (state_r != F_IDLE);
    req_valid = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (in_push) begin
          op_nxt    = in_opcode;
          key_nxt   = in_key;
          data_nxt  = in_entry_data;
          shift_nxt = in_key;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        rem_nxt   = (rem_sh >= size_n) ? rem_sh - size_n : rem_sh;
        shift_nxt = {shift_r[KEY_W-2:0], 1'b0};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(KEY_W - 1)) begin
          state_nxt = F_HOLD;
        end
      end
      F_HOLD: begin
        req_valid = 1'b1;
        if (req_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request payload and divider registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    data_r  <= data_nxt;
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
  end

  // fields in struct order: op, key, data, home
  assign req = {op_r, key_r, data_r, rem_r[IDX_W-1:0]};

endmodule

FILE: rtl/core/lpkt_queue.sv
// ----------------------------------------------------------------------------
// lpkt_queue
// Short request queue that decouples the hash front from the probe back.
// ----------------------------------------------------------------------------
module lpkt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           ready,
  input  lpkt_pkg::req_t wr_req,
  input  logic           pop,
  output logic           valid,
  output lpkt_pkg::req_t rd_req
);
  import lpkt_pkg::*;

  req_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, rptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_push, do_pop;

  assign ready   = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign valid   = (cnt_r != '0);
  assign do_push = push && ready;
  assign do_pop  = pop && valid;
  assign rd_req  = mem_r[rptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr_req;
    end
  end

endmodule

FILE: rtl/core/lpkt_back.sv
// ----------------------------------------------------------------------------
// lpkt_back
// Probe engine: walks slots from the home slot, updates the marks and
// the key and data RAMs, and holds the result for the output side.
// ----------------------------------------------------------------------------
module lpkt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lpkt_pkg::SIZE_W-1:0]   size_n,
  input  logic                          req_valid,
  output logic                          req_pop,
  input  lpkt_pkg::req_t                req,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [lpkt_pkg::STAT_W-1:0]   out_status,
  output logic [lpkt_pkg::SLOT_W-1:0]   out_slot,
  output logic [lpkt_pkg::FIELD_W-1:0]  out_found_data,
  output logic                          out_is_active
);
  import lpkt_pkg::*;

  back_state_t          state_r, state_nxt;
  req_t                 req_r, req_nxt;
  logic [IDX_W-1:0]     k_r, k_nxt;
  logic [SIZE_W-1:0]    j_r, j_nxt;
  logic [STAT_W-1:0]    res_stat_r, res_stat_nxt;
  logic [IDX_W-1:0]     res_slot_r, res_slot_nxt;
  logic [FIELD_W-1:0]   res_data_r, res_data_nxt;
  logic                 res_act_r, res_act_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    out_stat_r;
  logic [IDX_W-1:0]     out_slot_r;
  logic [FIELD_W-1:0]   out_data_r;
  logic                 out_act_r;
  logic                 out_load;

  logic [TABLE_DEPTH-1:0] used_r, active_r;
  logic                   set_used, set_active;

  logic                  ram_we;
  logic [KEY_W-1:0]      key_rd;
  logic [DATA_WIDTH-1:0] data_rd;

  logic [SIZE_W-1:0]     k_inc;
  logic [IDX_W-1:0]      k_wrap;
  logic                  last_probe;
  logic                  key_hit;

  // next probe position with wrap at the table size
  assign k_inc      = {1'b0, k_r} + 1'b1;
  assign k_wrap     = (k_inc == size_n) ? '0 : k_inc[IDX_W-1:0];
  assign last_probe = ((j_r + 1'b1) == size_n);
  assign key_hit    = used_r[k_r] && (key_rd == req_r.key);

  // stored keys and payloads
  lpkt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (k_r),
    .wdata (req_r.key),
    .raddr (k_r),
    .rdata (key_rd)
  );

  lpkt_ram #(.WIDTH(DATA_WIDTH), .DEPTH(TABLE_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (k_r),
    .wdata (DATA_WIDTH'(req_r.data)),
    .raddr (k_r),
    .rdata (data_rd)
  );

  // probe sequencer
  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    k_nxt        = k_r;
    j_nxt        = j_r;
    res_stat_nxt = res_stat_r;
    res_slot_nxt = res_slot_r;
    res_data_nxt = res_data_r;
    res_act_nxt  = res_act_r;
    req_pop      = 1'b0;
    ram_we       = 1'b0;
    set_used     = 1'b0;
    set_active   = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (req_valid) begin
          req_pop   = 1'b1;
          req_nxt   = req;
          k_nxt     = req.home;
          j_nxt     = '0;
          state_nxt = B_READ;
        end
      end
      B_READ: begin
        case (req_r.op)
          OP_INSERT: begin
            if (!used_r[k_r]) begin
              ram_we       = 1'b1;
              set_used     = 1'b1;
              res_stat_nxt = ST_OK;
              res_slot_nxt = k_r;
              res_data_nxt = FIELD_W'(DATA_WIDTH'(req_r.data));
              res_act_nxt  = 1'b0;
              state_nxt    = B_DONE;
            end else if (last_probe) begin
              res_stat_nxt = ST_FULL;
              state_nxt    = B_DONE;
            end else begin
              k_nxt = k_wrap;
              j_nxt = j_r + 1'b1;
            end
          end
          OP_LOOKUP, OP_MARK: begin
            state_nxt = B_CMP;
          end
          default: begin
            res_stat_nxt = ST_NOT_FOUND;
            state_nxt    = B_DONE;
          end
        endcase
      end
      B_CMP: begin
        if (key_hit) begin
          set_active   = (req_r.op == OP_MARK);
          res_stat_nxt = ST_OK;
          res_slot_nxt = k_r;
          res_data_nxt = FIELD_W'(data_rd);
          res_act_nxt  = active_r[k_r] || (req_r.op == OP_MARK);
          state_nxt    = B_DONE;
        end else if (last_probe) begin
          res_stat_nxt = ST_NOT_FOUND;
          state_nxt    = B_DONE;
        end else begin
          k_nxt     = k_wrap;
          j_nxt     = j_r + 1'b1;
          state_nxt = B_READ;
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_pop) begin
          out_load  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // output register valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers and slot marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      active_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (set_used) begin
        used_r[k_r]   <= 1'b1;
        active_r[k_r] <= 1'b0;
      end
      if (set_active) begin
        active_r[k_r] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    res_stat_r <= res_stat_nxt;
    res_slot_r <= res_slot_nxt;
    res_data_r <= res_data_nxt;
    res_act_r  <= res_act_nxt;
    if (out_load) begin
      out_stat_r <= res_stat_r;
      if (res_stat_r == ST_OK) begin
        out_slot_r <= res_slot_r;
        out_data_r <= res_data_r;
        out_act_r  <= res_act_r;
      end else begin
        out_slot_r <= '0;
        out_data_r <= '0;
        out_act_r  <= 1'b0;
      end
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_status     = out_stat_r;
  assign out_slot       = SLOT_W'(out_slot_r);
  assign out_found_data = out_data_r;
  assign out_is_active  = out_act_r;

endmodule

FILE: rtl/core/linear_probe_key_table_top.sv
// ----------------------------------------------------------------------------
// linear_probe_key_table_top
// Open-addressing key table with linear probing, insert, lookup and mark.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through a queue-style port: drive in_opcode, in_key and
//   in_entry_data and raise in_push; the request is taken on a clock edge
//   with in_full low. Results leave the same way: while out_empty is low
//   the oldest result sits on the out_ ports and is taken with out_pop.
//   cfg_we with cfg_wdata sets the table size (0 acts as 1, above the
//   depth acts as the depth); write it only while the block is idle.
// Timing:
//   the front works out the home slot one key bit at a time and takes
//   no new request until it has handed the current one to the queue.
//   The back probes one slot per cycle for insert; lookup and mark read
//   the key RAM in one state and compare in the next for each slot, and
//   an unknown opcode ends in the read state with status not found.
//   Front and back overlap through a two-entry request queue, so long
//   probes slow the input only once that queue is full.
// Reset and stall:
//   reset clears all used and active marks and sets the size to 256.
//   A result waiting on the output lets the back start the next request;
//   the back then holds its finished result until the output is popped.
// ----------------------------------------------------------------------------
module linear_probe_key_table_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [lpkt_pkg::OP_W-1:0]     in_opcode,
  input  logic [lpkt_pkg::KEY_W-1:0]    in_key,
  input  logic [lpkt_pkg::FIELD_W-1:0]  in_entry_data,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [lpkt_pkg::STAT_W-1:0]   out_status,
  output logic [lpkt_pkg::SLOT_W-1:0]   out_slot,
  output logic [lpkt_pkg::FIELD_W-1:0]  out_found_data,
  output logic                          out_is_active,
  input  logic                          cfg_we,
  input  logic [lpkt_pkg::CFG_W-1:0]    cfg_wdata
);
  import lpkt_pkg::*;

  logic [CFG_W-1:0]  size_cfg_r;
  logic [SIZE_W-1:0] size_n;
  logic              f_valid, q_ready, q_valid, q_pop;
  req_t              f_req, q_req;

  // table size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r <= CFG_W'(TABLE_DEPTH);
    end else if (cfg_we) begin
      size_cfg_r <= cfg_wdata;
    end
  end

  // effective size, clamped to one and to the table depth
  always_comb begin
    if (size_cfg_r == '0) begin
      size_n = SIZE_W'(1);
    end else if ({1'b0, size_cfg_r} > (CFG_W + 1)'(TABLE_DEPTH)) begin
      size_n = SIZE_W'(TABLE_DEPTH);
    end else begin
      size_n = SIZE_W'(size_cfg_r);
    end
  end

  lpkt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_opcode     (in_opcode),
    .in_key        (in_key),
    .in_entry_data (in_entry_data),
    .size_n        (size_n),
    .req_valid     (f_valid),
    .req_ready     (q_ready),
    .req           (f_req)
  );

  lpkt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (f_valid),
    .ready  (q_ready),
    .wr_req (f_req),
    .pop    (q_pop),
    .valid  (q_valid),
    .rd_req (q_req)
  );

  lpkt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .size_n         (size_n),
    .req_valid      (q_valid),
    .req_pop        (q_pop),
    .req            (q_req),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_found_data (out_found_data),
    .out_is_active  (out_is_active)
  );

endmodule
